/* hw/rtl/etf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package etf_pkg;

  // Number format: signed, four integer bits including the sign.
  localparam int FRAC_BITS = 28;
  localparam int FMT_W     = FRAC_BITS + 4;
  localparam int WIDE_W    = 2 * FMT_W;
  localparam int SUM_W     = FMT_W + 1;

  // Field widths.
  localparam int PIX_W   = 10;
  localparam int ZOOM_W  = 31;
  localparam int ITER_W  = 11;
  localparam int REG_W   = 32;
  localparam int ADDR_W  = 5;
  localparam int PROD_W  = ZOOM_W + PIX_W;

  // Image geometry; both sizes are powers of two, so the scaling is a shift.
  localparam int IMAGE_COLS = 1024;
  localparam int IMAGE_ROWS = 1024;
  localparam int COL_SHIFT  = $clog2(IMAGE_COLS);
  localparam int ROW_SHIFT  = $clog2(IMAGE_ROWS);

  localparam int MAX_ITER_BOUND = 1024;

  typedef logic signed [FMT_W-1:0]  fmt_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam fmt_t  FMT_MAX      = {1'b0, {(FMT_W-1){1'b1}}};
  localparam fmt_t  FMT_MIN      = {1'b1, {(FMT_W-1){1'b0}}};
  localparam wide_t FMT_MAX_WIDE = wide_t'(FMT_MAX);
  localparam wide_t FMT_MIN_WIDE = wide_t'(FMT_MIN);

  // Escape threshold |z|^2 > 4.0.
  localparam logic [SUM_W-1:0] ESC_LIMIT = SUM_W'(4) << FRAC_BITS;

  // Register reset values.
  localparam logic [ZOOM_W-1:0] ZOOM_RESET  = ZOOM_W'(268435456);
  localparam logic [ITER_W-1:0] LIMIT_RESET = ITER_W'(64);

  // Fractal modes.
  localparam logic MODE_MANDEL = 1'b0;
  localparam logic MODE_JULIA  = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_ZOOM       = 3'd1,
    REG_SHIFT_RE   = 3'd2,
    REG_SHIFT_IM   = 3'd3,
    REG_JULIA_RE   = 3'd4,
    REG_JULIA_IM   = 3'd5,
    REG_ITER_LIMIT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  out_col;
    logic [PIX_W-1:0]  out_row;
    logic [ITER_W-1:0] iter_count;
    logic              escaped;
  } result_t;

  typedef struct packed {
    logic              mode;
    logic [ZOOM_W-1:0] zoom;
    fmt_t              shift_re;
    fmt_t              shift_im;
    fmt_t              julia_re;
    fmt_t              julia_im;
    logic [ITER_W-1:0] iter_limit;
  } cfg_t;

  // Clamp a wide signed value to the number format.
  function automatic fmt_t sat_fmt(input wide_t v);
    fmt_t r;
    if (v > FMT_MAX_WIDE) begin
      r = FMT_MAX;
    end else if (v < FMT_MIN_WIDE) begin
      r = FMT_MIN;
    end else begin
      r = v[FMT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/etf_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module etf_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [etf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [etf_pkg::REG_W-1:0]   pwdata,
  output logic [etf_pkg::REG_W-1:0]        prdata,
  output logic                             pready,
  output etf_pkg::cfg_t                    cfg
);

  logic                wr_en;
  etf_pkg::reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = etf_pkg::reg_idx_t'(paddr[etf_pkg::ADDR_W-1:2]);

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= etf_pkg::MODE_MANDEL;
      cfg.zoom       <= etf_pkg::ZOOM_RESET;
      cfg.shift_re   <= '0;
      cfg.shift_im   <= '0;
      cfg.julia_re   <= '0;
      cfg.julia_im   <= '0;
      cfg.iter_limit <= etf_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        etf_pkg::REG_MODE:       cfg.mode       <= pwdata[0];
        etf_pkg::REG_ZOOM:       cfg.zoom       <= pwdata[etf_pkg::ZOOM_W-1:0];
        etf_pkg::REG_SHIFT_RE:   cfg.shift_re   <= pwdata[etf_pkg::FMT_W-1:0];
        etf_pkg::REG_SHIFT_IM:   cfg.shift_im   <= pwdata[etf_pkg::FMT_W-1:0];
        etf_pkg::REG_JULIA_RE:   cfg.julia_re   <= pwdata[etf_pkg::FMT_W-1:0];
        etf_pkg::REG_JULIA_IM:   cfg.julia_im   <= pwdata[etf_pkg::FMT_W-1:0];
        etf_pkg::REG_ITER_LIMIT: cfg.iter_limit <= pwdata[etf_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    unique case (idx)
      etf_pkg::REG_MODE:       prdata = etf_pkg::REG_W'(cfg.mode);
      etf_pkg::REG_ZOOM:       prdata = etf_pkg::REG_W'(cfg.zoom);
      etf_pkg::REG_SHIFT_RE:   prdata = etf_pkg::REG_W'(cfg.shift_re);
      etf_pkg::REG_SHIFT_IM:   prdata = etf_pkg::REG_W'(cfg.shift_im);
      etf_pkg::REG_JULIA_RE:   prdata = etf_pkg::REG_W'(cfg.julia_re);
      etf_pkg::REG_JULIA_IM:   prdata = etf_pkg::REG_W'(cfg.julia_im);
      etf_pkg::REG_ITER_LIMIT: prdata = etf_pkg::REG_W'(cfg.iter_limit);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/etf_map.sv */
`timescale 1ns / 1ps
`default_nettype none

module etf_map (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire etf_pkg::in_item_t          item,
  input  wire etf_pkg::cfg_t              cfg,
  output etf_pkg::fmt_t                   pre,
  output etf_pkg::fmt_t                   pim
);

  logic [etf_pkg::PROD_W-1:0] prod_col;
  logic [etf_pkg::PROD_W-1:0] prod_row;
  etf_pkg::wide_t             term_re;
  etf_pkg::wide_t             term_im;
  etf_pkg::wide_t             two_zoom;

  // zoom * pixel position, captured with the accepted transfer.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_col <= etf_pkg::PROD_W'(cfg.zoom) * etf_pkg::PROD_W'(item.pixel_col);
      prod_row <= etf_pkg::PROD_W'(cfg.zoom) * etf_pkg::PROD_W'(item.pixel_row);
    end
  end

  // floor(4*zoom*pos / size) is the product scaled by four and shifted down.
  assign term_re  = etf_pkg::wide_t'({prod_col, 2'b00} >> etf_pkg::COL_SHIFT);
  assign term_im  = etf_pkg::wide_t'({prod_row, 2'b00} >> etf_pkg::ROW_SHIFT);
  assign two_zoom = etf_pkg::wide_t'({cfg.zoom, 1'b0});

  // Map onto the plane with the imaginary axis flipped, then saturate once.
  assign pre = etf_pkg::sat_fmt(term_re - two_zoom + etf_pkg::wide_t'(cfg.shift_re));
  assign pim = etf_pkg::sat_fmt(two_zoom - term_im + etf_pkg::wide_t'(cfg.shift_im));

endmodule

`default_nettype wire

/* hw/rtl/etf_sqr.sv */
`timescale 1ns / 1ps
`default_nettype none

module etf_sqr (
  input  wire logic           clk,
  input  wire etf_pkg::fmt_t  zr,
  input  wire etf_pkg::fmt_t  zi,
  output etf_pkg::fmt_t       sq_r,
  output etf_pkg::fmt_t       sq_i,
  output etf_pkg::fmt_t       cross_term
);

  etf_pkg::wide_t p_rr;
  etf_pkg::wide_t p_ii;
  etf_pkg::wide_t p_ri;

  // Shared multiplier set: zr^2, zi^2 and zr*zi.
  assign p_rr = zr * zr;
  assign p_ii = zi * zi;
  assign p_ri = zr * zi;

  // Arithmetic shift rounds toward minus infinity; the cross term carries
  // the factor of two by shifting one bit less.
  always_ff @(posedge clk) begin
    sq_r       <= etf_pkg::sat_fmt(p_rr >>> etf_pkg::FRAC_BITS);
    sq_i       <= etf_pkg::sat_fmt(p_ii >>> etf_pkg::FRAC_BITS);
    cross_term <= etf_pkg::sat_fmt(p_ri >>> (etf_pkg::FRAC_BITS - 1));
  end

endmodule

`default_nettype wire

/* hw/rtl/escape_time_fractal_iterator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake                        Payload
// input      start, busy (accept: start&!busy) item   (pixel_col, pixel_row)
// result     done (one-cycle strobe)          result (out_col, out_row,
//                                                      iter_count, escaped)
// config     APB psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A pixel performs 0 to 1024 iterations between its accepted transfer and its result strobe. It
// is first mapped onto the plane; then each escape check and each iteration takes one pass
// through the shared multiplier set and one through the update logic.
// busy is high from the accepting edge until the result is registered.
// Synchronous reset clears the sequencer, the strobe and the configuration registers.
// The receiver cannot stall: done flags each result for exactly one cycle.

module escape_time_fractal_iterator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire etf_pkg::in_item_t           item,
  output logic                             busy,
  output logic                             done,
  output etf_pkg::result_t                 result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [etf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [etf_pkg::REG_W-1:0]   pwdata,
  output logic [etf_pkg::REG_W-1:0]        prdata,
  output logic                             pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t                       state;
  state_t                       state_next;
  etf_pkg::cfg_t                cfg;
  etf_pkg::fmt_t                pre;
  etf_pkg::fmt_t                pim;
  etf_pkg::fmt_t                zr;
  etf_pkg::fmt_t                zi;
  etf_pkg::fmt_t                cr;
  etf_pkg::fmt_t                ci;
  etf_pkg::fmt_t                sq_r;
  etf_pkg::fmt_t                sq_i;
  etf_pkg::fmt_t                cross_term;
  etf_pkg::fmt_t                diff;
  logic [etf_pkg::ITER_W-1:0]   count;
  logic [etf_pkg::ITER_W-1:0]   limit;
  logic [etf_pkg::ITER_W-1:0]   limit_next;
  logic [etf_pkg::PIX_W-1:0]    col;
  logic [etf_pkg::PIX_W-1:0]    row;
  logic [etf_pkg::SUM_W-1:0]    mag_sq;
  logic                         accept;
  logic                         esc;
  logic                         at_limit;
  logic                         finish;

  etf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  etf_map u_map (
    .clk  (clk),
    .load (accept),
    .item (item),
    .cfg  (cfg),
    .pre  (pre),
    .pim  (pim)
  );

  etf_sqr u_sqr (
    .clk        (clk),
    .zr         (zr),
    .zi         (zi),
    .sq_r       (sq_r),
    .sq_i       (sq_i),
    .cross_term (cross_term)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;

  // Escape test on the squares of the current z; skipped before the first
  // iteration. Squares are never negative, so the sum is taken unsigned.
  assign mag_sq   = {1'b0, sq_r} + {1'b0, sq_i};
  assign esc      = (count != '0) && (mag_sq > etf_pkg::ESC_LIMIT);
  assign at_limit = (count == limit);
  assign finish   = esc | at_limit;
  assign diff     = etf_pkg::sat_fmt(etf_pkg::wide_t'(sq_r) - etf_pkg::wide_t'(sq_i));

  // Iteration limit clamped to the supported bound.
  assign limit_next = (cfg.iter_limit > etf_pkg::ITER_W'(etf_pkg::MAX_ITER_BOUND)) ?
                      etf_pkg::ITER_W'(etf_pkg::MAX_ITER_BOUND) : cfg.iter_limit;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_MUL;
      ST_MUL:  state_next = ST_UPD;
      ST_UPD: begin
        state_next = finish ? ST_IDLE : ST_MUL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPD) && finish;
    end
  end

  // Datapath: pixel capture, start values, iteration update and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      col <= item.pixel_col;
      row <= item.pixel_row;
    end
    if (state == ST_LOAD) begin
      count <= '0;
      limit <= limit_next;
      if (cfg.mode == etf_pkg::MODE_JULIA) begin
        zr <= pre;
        zi <= pim;
        cr <= cfg.julia_re;
        ci <= cfg.julia_im;
      end else begin
        zr <= '0;
        zi <= '0;
        cr <= pre;
        ci <= pim;
      end
    end
    if (state == ST_UPD) begin
      if (finish) begin
        result.out_col    <= col;
        result.out_row    <= row;
        result.iter_count <= count;
        result.escaped    <= esc & ~at_limit;
      end else begin
        zr    <= etf_pkg::sat_fmt(etf_pkg::wide_t'(diff) + etf_pkg::wide_t'(cr));
        zi    <= etf_pkg::sat_fmt(etf_pkg::wide_t'(cross_term) + etf_pkg::wide_t'(ci));
        count <= count + etf_pkg::ITER_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
